// File: src/slt_pkg.sv
package slt_pkg;

  localparam int DEPTH = 16;
  localparam int ENT_W = 32;
  localparam int POS_W = 5;
  localparam int ACT_W = 3;
  localparam int ST_W  = 2;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_GET_WAIT,
    S_LOC,
    S_DEL_RD,
    S_DEL_SH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [ENT_W-1:0] value;
    logic [POS_W-1:0]        position;
  } item_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] result_value;
    logic [POS_W-1:0]        found_position;
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        entry_count;
    logic                    is_empty;
  } resp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: src/slt_mem.sv
module slt_mem (
  input  logic                             clk,
  input  slt_pkg::mem_req_t                req,
  output logic [slt_pkg::ENT_W-1:0]        rdata
);

  logic [slt_pkg::ENT_W-1:0] mem [slt_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: src/slt_seq.sv
module slt_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  slt_pkg::item_t      item,
  output logic                idle,
  output logic                resp_valid,
  input  logic                resp_ready,
  output slt_pkg::resp_t      resp
);

  slt_pkg::state_t                   state, state_next;
  logic [slt_pkg::IDX_W-1:0]         idx, idx_next;
  logic [slt_pkg::CNT_W-1:0]         cnt, cnt_next;
  logic signed [slt_pkg::ENT_W-1:0]  val, val_next;
  logic signed [slt_pkg::ENT_W-1:0]  res_val, res_val_next;
  logic [slt_pkg::POS_W-1:0]         found, found_next;
  logic [slt_pkg::ST_W-1:0]          status, status_next;
  slt_pkg::mem_req_t                 req;
  logic signed [slt_pkg::ENT_W-1:0]  rdata;
  logic                              pos_ok;
  logic                              data_lt;
  logic                              data_eq;

  slt_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // compare unit for read data against the held value
  assign data_lt = $signed(rdata) < val;
  assign data_eq = rdata == val;

  assign pos_ok = (slt_pkg::CMP_W'(item.position) != '0) &&
                  (slt_pkg::CMP_W'(item.position) <= slt_pkg::CMP_W'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slt_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    val     <= val_next;
    res_val <= res_val_next;
    found   <= found_next;
    status  <= status_next;
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cnt_next     = cnt;
    val_next     = val;
    res_val_next = res_val;
    found_next   = found;
    status_next  = status;
    req          = '0;
    idle         = 1'b0;
    resp_valid   = 1'b0;

    case (state)
      slt_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          val_next     = item.value;
          res_val_next = '0;
          found_next   = '0;
          status_next  = slt_pkg::ST_MISS;
          state_next   = slt_pkg::S_RESP;
          case (item.action)
            slt_pkg::ACT_INSERT: begin
              if (cnt == slt_pkg::CNT_W'(slt_pkg::DEPTH)) begin
                status_next = slt_pkg::ST_FULL;
              end else if (cnt == '0) begin
                req.we      = 1'b1;
                req.waddr   = '0;
                req.wdata   = item.value;
                cnt_next    = cnt + 1'b1;
                status_next = slt_pkg::ST_OK;
              end else begin
                idx_next   = slt_pkg::IDX_W'(cnt - 1'b1);
                req.raddr  = slt_pkg::IDX_W'(cnt - 1'b1);
                state_next = slt_pkg::S_INS;
              end
            end
            slt_pkg::ACT_GET: begin
              if (pos_ok) begin
                req.raddr  = slt_pkg::IDX_W'(item.position - 1'b1);
                state_next = slt_pkg::S_GET_WAIT;
              end
            end
            slt_pkg::ACT_LOCATE: begin
              if (cnt != '0) begin
                idx_next   = '0;
                req.raddr  = '0;
                state_next = slt_pkg::S_LOC;
              end
            end
            slt_pkg::ACT_DELETE: begin
              if (pos_ok) begin
                idx_next   = slt_pkg::IDX_W'(item.position - 1'b1);
                req.raddr  = slt_pkg::IDX_W'(item.position - 1'b1);
                state_next = slt_pkg::S_DEL_RD;
              end
            end
            slt_pkg::ACT_CLEAR: begin
              cnt_next    = '0;
              status_next = slt_pkg::ST_OK;
            end
            default: begin
              status_next = slt_pkg::ST_MISS;
            end
          endcase
        end
      end

      // walk down from the top, moving entries not smaller than the new value
      slt_pkg::S_INS: begin
        req.we = 1'b1;
        req.waddr = slt_pkg::IDX_W'(idx + 1'b1);
        if (!data_lt) begin
          req.wdata = rdata;
          if (idx == '0) begin
            state_next = slt_pkg::S_INS_LAST;
          end else begin
            req.raddr = idx - 1'b1;
            idx_next  = idx - 1'b1;
          end
        end else begin
          req.wdata   = val;
          cnt_next    = cnt + 1'b1;
          status_next = slt_pkg::ST_OK;
          state_next  = slt_pkg::S_RESP;
        end
      end

      slt_pkg::S_INS_LAST: begin
        req.we      = 1'b1;
        req.waddr   = '0;
        req.wdata   = val;
        cnt_next    = cnt + 1'b1;
        status_next = slt_pkg::ST_OK;
        state_next  = slt_pkg::S_RESP;
      end

      slt_pkg::S_GET_WAIT: begin
        res_val_next = rdata;
        status_next  = slt_pkg::ST_OK;
        state_next   = slt_pkg::S_RESP;
      end

      slt_pkg::S_LOC: begin
        if (data_eq) begin
          found_next  = slt_pkg::POS_W'(slt_pkg::CNT_W'(idx) + 1'b1);
          status_next = slt_pkg::ST_OK;
          state_next  = slt_pkg::S_RESP;
        end else if (slt_pkg::CNT_W'(idx) + 1'b1 == cnt) begin
          state_next = slt_pkg::S_RESP;
        end else begin
          req.raddr = slt_pkg::IDX_W'(idx + 1'b1);
          idx_next  = slt_pkg::IDX_W'(idx + 1'b1);
        end
      end

      slt_pkg::S_DEL_RD: begin
        res_val_next = rdata;
        status_next  = slt_pkg::ST_OK;
        if (slt_pkg::CNT_W'(idx) + 1'b1 == cnt) begin
          cnt_next   = cnt - 1'b1;
          state_next = slt_pkg::S_RESP;
        end else begin
          req.raddr  = slt_pkg::IDX_W'(idx + 1'b1);
          state_next = slt_pkg::S_DEL_SH;
        end
      end

      // rdata holds entry idx+1, which moves down to idx
      slt_pkg::S_DEL_SH: begin
        req.we    = 1'b1;
        req.waddr = idx;
        req.wdata = rdata;
        if (slt_pkg::CNT_W'(idx) + slt_pkg::CNT_W'(2) == cnt) begin
          cnt_next   = cnt - 1'b1;
          state_next = slt_pkg::S_RESP;
        end else begin
          req.raddr = slt_pkg::IDX_W'(slt_pkg::CNT_W'(idx) + slt_pkg::CNT_W'(2));
          idx_next  = slt_pkg::IDX_W'(idx + 1'b1);
        end
      end

      slt_pkg::S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_next = slt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slt_pkg::S_IDLE;
      end
    endcase
  end

  assign resp.result_value   = res_val;
  assign resp.found_position = found;
  assign resp.status         = status;
  assign resp.entry_count    = slt_pkg::POS_W'(cnt);
  assign resp.is_empty       = (cnt == '0);

endmodule

// File: src/sorted_list_table.sv
// channel  dir  tdata                                            tuser
// s_axis   in   value[31:0] position[36:32] pad[39:37]            action[2:0]
// m_axis   out  result_value[31:0] found_position[36:32]          -
//               status[38:37] entry_count[43:39] is_empty[44] pad[47:45]
//
// One transaction at a time through a single sequencer and a one-read,
// one-write entry RAM.
// Insert scans/shifts down from the top, delete shifts higher entries down,
// locate scans up, get reads one entry; clear and rejections skip the RAM.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
// A finished result sits in the output register while the next transaction
// is accepted; the sequencer holds its own result until that register frees.
module sorted_list_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value, position
  input  logic [2:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // result_value, found_position, status,
                                      // entry_count, is_empty
);

  slt_pkg::item_t item;
  slt_pkg::resp_t resp;
  slt_pkg::resp_t out_q;
  logic           seq_idle;
  logic           resp_valid;
  logic           resp_ready;
  logic           start;

  assign item.action   = s_axis_tuser;
  assign item.value    = s_axis_tdata[31:0];
  assign item.position = s_axis_tdata[36:32];

  assign s_axis_tready = seq_idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign resp_ready    = !m_axis_tvalid || m_axis_tready;

  slt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .idle       (seq_idle),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (resp_ready) begin
      m_axis_tvalid <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_q <= resp;
    end
  end

  assign m_axis_tdata = {3'b000, out_q.is_empty, out_q.entry_count, out_q.status,
                         out_q.found_position, out_q.result_value};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_q.entry_count <= slt_pkg::POS_W'(slt_pkg::DEPTH)))
    else $error("entry count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_q.is_empty == (out_q.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_q.status == slt_pkg::ST_FULL) |->
      (out_q.entry_count == slt_pkg::POS_W'(slt_pkg::DEPTH)))
    else $error("full status with table not full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !resp_valid)
    else $error("ready while result pending in sequencer");

endmodule

// File: verif/slt_reply_checker.sv
`timescale 1ns / 100ps

module slt_reply_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value, position
  input  logic [2:0]  s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // result_value, found_position, status,
                                      // entry_count, is_empty
  output int          mismatches,
  output int          in_flight,
  output int          replies_checked,
  output int          full_refusals
);

  logic signed [slt_pkg::ENT_W-1:0] sorted_copy [slt_pkg::DEPTH];
  int                               copy_count;
  slt_pkg::resp_t                   replies_due [$];

  initial begin
    mismatches      = 0;
    in_flight       = 0;
    replies_checked = 0;
    full_refusals   = 0;
    copy_count      = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      report_error($sformatf("reply %0d %s: expected %0d, got %0d",
                             replies_checked, name, want_v, got_v));
    end
  endtask

  // Applies one action to the shadow table and returns the reply it must produce.
  task automatic apply_to_copy(input logic [slt_pkg::ACT_W-1:0] act,
                               input logic signed [slt_pkg::ENT_W-1:0] val,
                               input logic [slt_pkg::POS_W-1:0] pos,
                               output slt_pkg::resp_t r);
    int at;
    r = '0;
    r.status = slt_pkg::ST_MISS;
    case (act)
      slt_pkg::ACT_INSERT: begin
        if (copy_count >= slt_pkg::DEPTH) begin
          r.status = slt_pkg::ST_FULL;
        end else begin
          at = 0;
          while (at < copy_count && sorted_copy[at] < val) at++;
          for (int i = copy_count; i > at; i--) sorted_copy[i] = sorted_copy[i-1];
          sorted_copy[at] = val;
          copy_count++;
          r.status = slt_pkg::ST_OK;
        end
      end
      slt_pkg::ACT_GET: begin
        if (pos >= 1 && pos <= copy_count) begin
          r.result_value = sorted_copy[pos-1];
          r.status = slt_pkg::ST_OK;
        end
      end
      slt_pkg::ACT_LOCATE: begin
        for (int i = 0; i < copy_count; i++) begin
          if (sorted_copy[i] == val) begin
            r.found_position = slt_pkg::POS_W'(i + 1);
            r.status = slt_pkg::ST_OK;
            break;
          end
        end
      end
      slt_pkg::ACT_DELETE: begin
        if (pos >= 1 && pos <= copy_count) begin
          r.result_value = sorted_copy[pos-1];
          for (int i = pos - 1; i + 1 < copy_count; i++) sorted_copy[i] = sorted_copy[i+1];
          copy_count--;
          r.status = slt_pkg::ST_OK;
        end
      end
      slt_pkg::ACT_CLEAR: begin
        copy_count = 0;
        r.status = slt_pkg::ST_OK;
      end
      default: begin
      end
    endcase
    r.entry_count = slt_pkg::POS_W'(copy_count);
    r.is_empty    = (copy_count == 0);
  endtask

  always @(posedge clk) begin : watch_channels
    slt_pkg::resp_t want;
    slt_pkg::resp_t seen;
    if (rst) begin
      copy_count = 0;
      replies_due.delete();
      in_flight <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_to_copy(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32], want);
        replies_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.result_value   = m_axis_tdata[31:0];
        seen.found_position = m_axis_tdata[36:32];
        seen.status         = m_axis_tdata[38:37];
        seen.entry_count    = m_axis_tdata[43:39];
        seen.is_empty       = m_axis_tdata[44];
        replies_checked++;
        if (replies_due.size() == 0) begin
          report_error($sformatf("reply %0d arrived with no transaction outstanding",
                                 replies_checked));
        end else begin
          want = replies_due.pop_front();
          if (want.status == slt_pkg::ST_FULL) full_refusals++;
          check_field("result_value", want.result_value, seen.result_value);
          check_field("found_position", want.found_position, seen.found_position);
          check_field("status", want.status, seen.status);
          check_field("entry_count", want.entry_count, seen.entry_count);
          check_field("is_empty", want.is_empty, seen.is_empty);
        end
      end
      in_flight <= replies_due.size();
    end
  end

endmodule

// File: verif/tb_sorted_list_table.sv
`timescale 1ns / 100ps

module tb_sorted_list_table;

  localparam int STALL_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int BLOCKS         = 36;
  localparam int BLOCK_ITEMS    = 40;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  int mismatches;
  int in_flight;
  int replies_checked;
  int full_refusals;

  int  sent;
  int  directed_sent;
  int  drains;
  int  hold_reqs;
  int  idle_cycles;
  bit  tx_steady;
  bit  rx_steady;
  logic signed [slt_pkg::ENT_W-1:0] recent_values [$];

  sorted_list_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  slt_reply_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .in_flight       (in_flight),
    .replies_checked (replies_checked),
    .full_refusals   (full_refusals)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [slt_pkg::ENT_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 6) - 3;
    if (r < 55 && recent_values.size() > 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sh0;
        default: return -32'sh1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [slt_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 7) == 0) return slt_pkg::POS_W'($urandom_range(0, 31));
    return slt_pkg::POS_W'($urandom_range(0, slt_pkg::DEPTH + 1));
  endfunction

  function automatic logic [slt_pkg::ACT_W-1:0] pick_action(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 80) return slt_pkg::ACT_INSERT;
        if (r < 86) return slt_pkg::ACT_GET;
        if (r < 92) return slt_pkg::ACT_LOCATE;
        if (r < 98) return slt_pkg::ACT_DELETE;
      end
      MIX_BALANCED: begin
        if (r < 32) return slt_pkg::ACT_INSERT;
        if (r < 50) return slt_pkg::ACT_GET;
        if (r < 68) return slt_pkg::ACT_LOCATE;
        if (r < 92) return slt_pkg::ACT_DELETE;
        if (r < 97) return slt_pkg::ACT_CLEAR;
      end
      default: begin
        if (r < 15) return slt_pkg::ACT_INSERT;
        if (r < 30) return slt_pkg::ACT_GET;
        if (r < 45) return slt_pkg::ACT_LOCATE;
        if (r < 96) return slt_pkg::ACT_DELETE;
        if (r < 98) return slt_pkg::ACT_CLEAR;
      end
    endcase
    // unused action codes above clear
    return slt_pkg::ACT_CLEAR + slt_pkg::ACT_W'($urandom_range(1, 3));
  endfunction

  task automatic issue_action(input logic [slt_pkg::ACT_W-1:0] act,
                              input logic signed [slt_pkg::ENT_W-1:0] val,
                              input logic [slt_pkg::POS_W-1:0] pos);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {3'b000, pos, val};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    if (act == slt_pkg::ACT_INSERT) begin
      recent_values.push_back(val);
      if (recent_values.size() > 24) void'(recent_values.pop_front());
    end
  endtask

  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    drains++;
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  initial begin : rx_side
    int holds_done;
    int stall_left;
    holds_done    = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d replies outstanding",
               STALL_LIMIT, in_flight);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    mix_t mix;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    sent          = 0;
    drains        = 0;
    hold_reqs     = 0;
    idle_cycles   = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table corners
    issue_action(slt_pkg::ACT_GET, 0, 5'd1);
    issue_action(slt_pkg::ACT_DELETE, 0, 5'd1);
    issue_action(slt_pkg::ACT_LOCATE, 0, 5'd0);
    issue_action(slt_pkg::ACT_CLEAR, 0, 5'd0);
    // extremes and a duplicate
    issue_action(slt_pkg::ACT_INSERT, 32'sh7fffffff, 5'd0);
    issue_action(slt_pkg::ACT_INSERT, 32'sh80000000, 5'd0);
    issue_action(slt_pkg::ACT_INSERT, 0, 5'd0);
    issue_action(slt_pkg::ACT_INSERT, -1, 5'd0);
    issue_action(slt_pkg::ACT_INSERT, 0, 5'd31);
    issue_action(slt_pkg::ACT_LOCATE, 0, 5'd0);
    issue_action(slt_pkg::ACT_LOCATE, 12345, 5'd0);
    issue_action(slt_pkg::ACT_GET, 0, 5'd0);
    issue_action(slt_pkg::ACT_GET, 0, 5'd31);
    issue_action(slt_pkg::ACT_GET, 0, 5'd5);
    issue_action(slt_pkg::ACT_GET, 0, 5'd6);
    issue_action(slt_pkg::ACT_DELETE, 0, 5'd0);
    issue_action(slt_pkg::ACT_DELETE, 0, 5'd31);
    for (int c = int'(slt_pkg::ACT_CLEAR) + 1; c < 2**slt_pkg::ACT_W; c++)
      issue_action(slt_pkg::ACT_W'(c), -1, 5'd31);
    issue_action(slt_pkg::ACT_DELETE, 0, 5'd5);
    issue_action(slt_pkg::ACT_DELETE, 0, 5'd1);
    issue_action(slt_pkg::ACT_GET, 0, 5'd1);
    issue_action(slt_pkg::ACT_CLEAR, 0, 5'd0);
    issue_action(slt_pkg::ACT_GET, 0, 5'd1);
    directed_sent = sent;
    wait_for_replies();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      mix       = mix_t'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      if (blk == 6) begin
        tx_steady = 1'b1;
        hold_reqs <= hold_reqs + 1;
      end
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        issue_action(pick_action(mix), pick_value(), pick_position());
      end
      if (blk % 9 == 8) wait_for_replies();
    end

    wait_for_replies();
    repeat (40) @(posedge clk);
    if (in_flight != 0) $display("ERROR: %0d replies never arrived", in_flight);
    $display("Sent %0d transactions (%0d directed) in fill, balanced and drain mixes;",
             sent, directed_sent);
    $display("checked %0d replies, %0d inserts refused on a full table, %0d idle drains.",
             replies_checked, full_refusals, drains);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
